// File: hw/rtl/sphere_point_to_equirect_uv_macros.svh
// assertion macros for the equirectangular mapping block
`ifndef SPHERE_POINT_TO_EQUIRECT_UV_MACROS_SVH
`define SPHERE_POINT_TO_EQUIRECT_UV_MACROS_SVH

// implication checked on every clock edge out of reset
`define SPU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that must never be seen
`define SPU_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// File: hw/rtl/spu_pkg.sv
// types and constants shared by the equirectangular mapping block
package spu_pkg;

	localparam int unsigned SQRT_STAGES   = 24;
	localparam int unsigned CORDIC_STAGES = 22;
	localparam int unsigned ANG_W         = 26;
	localparam int unsigned CRD_W         = 34;
	localparam logic [22:0] ANG_RIGHT     = 23'd4194304;

	localparam logic [ANG_W-1:0] ATAN_TABLE [CORDIC_STAGES] = '{
		26'd2097152, 26'd1238021, 26'd654136, 26'd332050, 26'd166669, 26'd83416,
		26'd41718, 26'd20860, 26'd10430, 26'd5215, 26'd2608, 26'd1304, 26'd652,
		26'd326, 26'd163, 26'd81, 26'd41, 26'd20, 26'd10, 26'd5, 26'd3, 26'd1
	};

	typedef struct packed {
		logic [47:0] n;
		logic [26:0] rem;
		logic [23:0] root;
	} sqrt_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] x;
		logic signed [CRD_W-1:0] y;
		logic signed [ANG_W-1:0] acc;
	} cordic_t;

	typedef struct packed {
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] az;
		logic        xneg;
		logic        xzero;
		logic        zneg;
		logic        zzero;
		logic        yneg;
		logic        yzero;
		logic        zero_vec;
	} side_t;

endpackage

// File: hw/rtl/spu_sqrt_cell.sv
// one bit of the pipelined integer square root
module spu_sqrt_cell (
	input  logic          clk,
	input  spu_pkg::sqrt_t d,
	output spu_pkg::sqrt_t q
);
	import spu_pkg::*;

	logic [26:0] rem2;
	logic [26:0] trial;
	logic        ge;

	always_comb begin
		rem2  = {d.rem[24:0], d.n[47:46]};
		trial = {1'b0, d.root, 2'b01};
		ge    = (rem2 >= trial);
	end

	always_ff @(posedge clk) begin
		q.n    <= {d.n[45:0], 2'b00};
		q.rem  <= ge ? (rem2 - trial) : rem2;
		q.root <= {d.root[22:0], ge};
	end
endmodule

// File: hw/rtl/spu_cordic_cell.sv
// one vectoring step of the cordic chain
module spu_cordic_cell #(
	parameter int unsigned STAGE = 0
) (
	input  logic             clk,
	input  spu_pkg::cordic_t d,
	output spu_pkg::cordic_t q
);
	import spu_pkg::*;

	logic signed [CRD_W-1:0] dx;
	logic signed [CRD_W-1:0] dy;
	logic signed [ANG_W-1:0] ang;

	always_comb begin
		dx  = d.y >>> STAGE;
		dy  = d.x >>> STAGE;
		ang = $signed(ATAN_TABLE[STAGE]);
	end

	always_ff @(posedge clk) begin
		if (!d.y[CRD_W-1]) begin
			q.x   <= d.x + dx;
			q.y   <= d.y - dy;
			q.acc <= d.acc + ang;
		end else begin
			q.x   <= d.x - dx;
			q.y   <= d.y + dy;
			q.acc <= d.acc - ang;
		end
	end
endmodule

// File: hw/rtl/sphere_point_to_equirect_uv.sv
// top level: vertex position to equirectangular texture coordinates
// Fully pipelined: one item may start in every cycle and busy is never raised.
// Each item passes an input stage, a squaring stage, 24 square-root cells and
// 22 cordic cells (longitude and latitude side by side) and an output register;
// done is registered alongside the results. The receiver cannot stall the results.
module sphere_point_to_equirect_uv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] pos_z,
	output logic        done,
	output logic [15:0] u_coord,
	output logic [15:0] v_coord,
	output logic        zero_length
);
	import spu_pkg::*;

	localparam int unsigned LAT = 2 + SQRT_STAGES + CORDIC_STAGES;

	logic [LAT-1:0] vld_q;
	side_t          side_s1;
	side_t          side_s2;
	logic [31:0]    sq_s2;
	side_t          sd [SQRT_STAGES+CORDIC_STAGES+1];
	sqrt_t          sc [SQRT_STAGES+1];
	cordic_t        lon [CORDIC_STAGES+1];
	cordic_t        lat [CORDIC_STAGES+1];
	side_t          sf;
	logic [22:0]    a_cl;
	logic [22:0]    p_cl;
	logic [24:0]    lng;
	logic [23:0]    latv;
	logic [16:0]    u_full;
	logic [16:0]    v_full;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done  <= 1'b0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
			done  <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s1.ax       <= pos_x[15] ? 16'(-pos_x) : pos_x;
		side_s1.ay       <= pos_y[15] ? 16'(-pos_y) : pos_y;
		side_s1.az       <= pos_z[15] ? 16'(-pos_z) : pos_z;
		side_s1.xneg     <= pos_x[15];
		side_s1.xzero    <= (pos_x == '0);
		side_s1.zneg     <= pos_z[15];
		side_s1.zzero    <= (pos_z == '0);
		side_s1.yneg     <= pos_y[15];
		side_s1.yzero    <= (pos_y == '0);
		side_s1.zero_vec <= (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
		side_s2          <= side_s1;
		sq_s2            <= 32'(side_s1.ax * side_s1.ax) + 32'(side_s1.az * side_s1.az);
	end

	assign sd[0]      = side_s2;
	assign sc[0].n    = {sq_s2, 16'b0};
	assign sc[0].rem  = '0;
	assign sc[0].root = '0;

	for (genvar i = 0; i < SQRT_STAGES + CORDIC_STAGES; i++) begin : g_side
		always_ff @(posedge clk) begin
			sd[i+1] <= sd[i];
		end
	end

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
		spu_sqrt_cell u_cell (.clk(clk), .d(sc[i]), .q(sc[i+1]));
	end

	always_comb begin
		lon[0].x   = $signed({4'b0, sd[SQRT_STAGES].ax, 14'b0});
		lon[0].y   = $signed({4'b0, sd[SQRT_STAGES].az, 14'b0});
		lon[0].acc = '0;
		lat[0].x   = $signed({4'b0, sc[SQRT_STAGES].root, 6'b0});
		lat[0].y   = $signed({4'b0, sd[SQRT_STAGES].ay, 14'b0});
		lat[0].acc = '0;
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		spu_cordic_cell #(.STAGE(i)) u_lon (.clk(clk), .d(lon[i]), .q(lon[i+1]));
		spu_cordic_cell #(.STAGE(i)) u_lat (.clk(clk), .d(lat[i]), .q(lat[i+1]));
	end

	assign sf = sd[SQRT_STAGES+CORDIC_STAGES];

	always_comb begin
		// longitude angle with the axis cases
		if (sf.xzero)
			a_cl = ANG_RIGHT;
		else if (sf.zzero || lon[CORDIC_STAGES].acc[ANG_W-1])
			a_cl = '0;
		else if (lon[CORDIC_STAGES].acc > $signed({3'b0, ANG_RIGHT}))
			a_cl = ANG_RIGHT;
		else
			a_cl = lon[CORDIC_STAGES].acc[22:0];
		// latitude angle, pole when x and z are both zero
		if (sf.xzero && sf.zzero)
			p_cl = ANG_RIGHT;
		else if (sf.yzero || lat[CORDIC_STAGES].acc[ANG_W-1])
			p_cl = '0;
		else if (lat[CORDIC_STAGES].acc > $signed({3'b0, ANG_RIGHT}))
			p_cl = ANG_RIGHT;
		else
			p_cl = lat[CORDIC_STAGES].acc[22:0];
		if (!sf.xneg && !sf.zneg)
			lng = 25'(ANG_RIGHT) - 25'(a_cl);
		else if (!sf.xneg)
			lng = 25'(ANG_RIGHT) + 25'(a_cl);
		else if (sf.zneg || sf.zzero)
			lng = 25'(3 * 4194304) - 25'(a_cl);
		else
			lng = 25'(3 * 4194304) + 25'(a_cl);
		latv   = sf.yneg ? (24'(ANG_RIGHT) + 24'(p_cl)) : (24'(ANG_RIGHT) - 24'(p_cl));
		u_full = 17'((26'(lng) + 26'd128) >> 8);
		v_full = 17'((25'(latv) + 25'd64) >> 7);
	end

	always_ff @(posedge clk) begin
		if (sf.zero_vec) begin
			u_coord     <= '0;
			v_coord     <= '0;
			zero_length <= 1'b1;
		end else begin
			u_coord     <= u_full[16] ? 16'hFFFF : u_full[15:0];
			v_coord     <= v_full[16] ? 16'hFFFF : v_full[15:0];
			zero_length <= 1'b0;
		end
	end
endmodule

// File: hw/rtl/spu_checker.sv
// port-level checks for the equirectangular mapping block
`include "sphere_point_to_equirect_uv_macros.svh"

module spu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [15:0] u_coord,
	input logic [15:0] v_coord,
	input logic        zero_length
);
	`SPU_ASSERT_NEVER(a_never_busy, clk, arst_n, busy, "busy raised")
	`SPU_ASSERT_IMP(a_latency, clk, arst_n, done, $past(start, 49), "item without start")
	`SPU_ASSERT_IMP(a_zero_out, clk, arst_n, done && zero_length, (u_coord == 16'd0) && (v_coord == 16'd0), "zero vector with coordinates")
endmodule

bind sphere_point_to_equirect_uv spu_checker u_spu_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.u_coord(u_coord), .v_coord(v_coord), .zero_length(zero_length)
);
